>>> rtl/core/gray_world_white_balance_core_macros.svh
// Assertion macros shared by the gray-world white balance core.
`ifndef GRAY_WORLD_WHITE_BALANCE_CORE_MACROS_SVH
`define GRAY_WORLD_WHITE_BALANCE_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define GWWB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gwwb: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define GWWB_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gwwb: next-cycle check failed");

`endif

>>> rtl/core/gwwb_pkg.sv
// Types and constants of the gray-world white balance core.
`default_nettype none

package gwwb_pkg;

    localparam int PIX_W       = 8;
    localparam int GAIN_W      = 16;
    localparam int GAIN_CNT_W  = $clog2(GAIN_W);
    localparam int IN_TDATA_W  = 5 * PIX_W;
    localparam int OUT_TDATA_W = 3 * PIX_W + 3 * GAIN_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHROMA_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHROMA_LOW  = 1'b1;
    localparam logic [PIX_W-1:0] CHROMA_HIGH_RST = 8'd145;
    localparam logic [PIX_W-1:0] CHROMA_LOW_RST  = 8'd110;

    localparam logic [GAIN_W-1:0] GAIN_MAX = 16'hFFFF;
    localparam logic [PIX_W-1:0]  PIX_MAX  = 8'hFF;

    // Queue depth must stay a power of two: pointers wrap by overflow.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic             last;
        logic             near_gray;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } gwwb_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } gwwb_div_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/gwwb_queue.sv
// Short register queue between the classifying front and the processing back.
`default_nettype none

module gwwb_queue
    import gwwb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire gwwb_item_t push_item,
    output logic            full,
    input  wire logic       pop,
    output logic            valid,
    output gwwb_item_t      head
);

    gwwb_item_t             mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;

    assign full  = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/gwwb_front.sv
// Input side: chroma window registers and near-gray classification.
`default_nettype none

module gwwb_front
    import gwwb_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                  s_axis_tlast,
    input  wire logic                  q_full,
    output logic                       q_push,
    output gwwb_item_t                 q_item
);

    logic [PIX_W-1:0] chroma_high_reg, chroma_high_next;
    logic [PIX_W-1:0] chroma_low_reg, chroma_low_next;
    logic [PIX_W-1:0] ca, cb;

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    assign ca = s_axis_tdata[4*PIX_W-1:3*PIX_W];
    assign cb = s_axis_tdata[5*PIX_W-1:4*PIX_W];

    always_comb begin
        q_item.blue      = s_axis_tdata[PIX_W-1:0];
        q_item.green     = s_axis_tdata[2*PIX_W-1:PIX_W];
        q_item.red       = s_axis_tdata[3*PIX_W-1:2*PIX_W];
        q_item.last      = s_axis_tlast;
        q_item.near_gray = (ca >= chroma_low_reg) && (ca <= chroma_high_reg) &&
                           (cb >= chroma_low_reg) && (cb <= chroma_high_reg);
    end

    always_comb begin
        chroma_high_next = chroma_high_reg;
        chroma_low_next  = chroma_low_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_IDX_CHROMA_HIGH: chroma_high_next = cfg_wr_data;
                CFG_IDX_CHROMA_LOW:  chroma_low_next  = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chroma_high_reg <= CHROMA_HIGH_RST;
            chroma_low_reg  <= CHROMA_LOW_RST;
        end else begin
            chroma_high_reg <= chroma_high_next;
            chroma_low_reg  <= chroma_low_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/gwwb_div.sv
// Restoring divider for one channel gain: round(total * 2^F / (3 * chan)), saturated.
`default_nettype none

module gwwb_div
    import gwwb_pkg::*;
#(
    parameter int PIXEL_COUNT_BITS = 22,
    parameter int GAIN_FRAC_BITS   = 12
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [PIXEL_COUNT_BITS+9:0] total,
    input  wire logic [PIXEL_COUNT_BITS+7:0] chan,
    output gwwb_div_stat_t                   stat,
    output logic [GAIN_W-1:0]                quot
);

    localparam int SUM_W = PIXEL_COUNT_BITS + 8;
    localparam int TOT_W = PIXEL_COUNT_BITS + 10;
    localparam int D3_W  = SUM_W + 2;
    localparam int D_W   = SUM_W + 3;
    localparam int N_W   = TOT_W + GAIN_FRAC_BITS + 2;
    localparam int CMP_W = D_W + GAIN_W;

    localparam logic [1:0] DV_IDLE  = 2'd0;
    localparam logic [1:0] DV_SETUP = 2'd1;
    localparam logic [1:0] DV_CHECK = 2'd2;
    localparam logic [1:0] DV_ITER  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic                  done_reg, done_next;
    logic [TOT_W-1:0]      total_reg, total_next;
    logic [D3_W-1:0]       d3_reg, d3_next;
    logic [N_W-1:0]        n_reg, n_next;
    logic [D_W-1:0]        d_reg, d_next;
    logic [D_W-1:0]        rem_reg, rem_next;
    logic [GAIN_W-1:0]     nlow_reg, nlow_next;
    logic [GAIN_W-1:0]     quot_reg, quot_next;
    logic [GAIN_CNT_W-1:0] cnt_reg, cnt_next;
    logic [D_W:0]          trial;
    logic                  trial_ge;

    assign stat.busy = (state_reg != DV_IDLE);
    assign stat.done = done_reg;
    assign quot      = quot_reg;

    assign trial    = {rem_reg, nlow_reg[GAIN_W-1]};
    assign trial_ge = (trial >= {1'b0, d_reg});

    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        total_next = total_reg;
        d3_next    = d3_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        nlow_next  = nlow_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            DV_IDLE: begin
                if (start) begin
                    if (chan == '0) begin
                        quot_next = GAIN_MAX;
                        done_next = 1'b1;
                    end else begin
                        total_next = total;
                        d3_next    = D3_W'(chan) + {1'b0, chan, 1'b0};
                        state_next = DV_SETUP;
                    end
                end
            end
            DV_SETUP: begin
                // Numerator carries the half-divisor term for round half up.
                n_next     = (N_W'(total_reg) << (GAIN_FRAC_BITS + 1)) + N_W'(d3_reg);
                d_next     = {d3_reg, 1'b0};
                state_next = DV_CHECK;
            end
            DV_CHECK: begin
                if (CMP_W'(n_reg) >= {d_reg, GAIN_W'(0)}) begin
                    quot_next  = GAIN_MAX;
                    done_next  = 1'b1;
                    state_next = DV_IDLE;
                end else begin
                    rem_next   = D_W'(n_reg >> GAIN_W);
                    nlow_next  = n_reg[GAIN_W-1:0];
                    quot_next  = '0;
                    cnt_next   = '0;
                    state_next = DV_ITER;
                end
            end
            DV_ITER: begin
                rem_next  = trial_ge ? D_W'(trial - {1'b0, d_reg}) : D_W'(trial);
                nlow_next = {nlow_reg[GAIN_W-2:0], 1'b0};
                quot_next = {quot_reg[GAIN_W-2:0], trial_ge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == GAIN_CNT_W'(GAIN_W - 1)) begin
                    done_next  = 1'b1;
                    state_next = DV_IDLE;
                end
            end
            default: state_next = DV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= total_next;
        d3_reg    <= d3_next;
        n_reg     <= n_next;
        d_reg     <= d_next;
        rem_reg   <= rem_next;
        nlow_reg  <= nlow_next;
        quot_reg  <= quot_next;
        cnt_reg   <= cnt_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/gwwb_back.sv
// Processing side: gain apply, gray sums, frame-end gain sequencing, output register.
`default_nettype none

module gwwb_back
    import gwwb_pkg::*;
#(
    parameter int PIXEL_COUNT_BITS = 22,
    parameter int GAIN_FRAC_BITS   = 12
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_valid,
    input  wire gwwb_item_t                  q_item,
    output logic                             q_pop,
    output logic                             div_start,
    output logic [PIXEL_COUNT_BITS+9:0]      div_total,
    output logic [PIXEL_COUNT_BITS+7:0]      div_chan,
    input  wire gwwb_div_stat_t              div_stat,
    input  wire logic [GAIN_W-1:0]           div_quot,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [OUT_TDATA_W-1:0]           m_axis_tdata,
    output logic                             m_axis_tuser
);

    localparam int SUM_W  = PIXEL_COUNT_BITS + 8;
    localparam int SUMX_W = SUM_W + 1;
    localparam int TOT_W  = PIXEL_COUNT_BITS + 10;
    localparam int PROD_W = PIX_W + GAIN_W + 1;
    localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1) << GAIN_FRAC_BITS;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_FRAC_BITS - 1);

    localparam logic [2:0] ST_RUN   = 3'd0;
    localparam logic [2:0] ST_TOTAL = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_WAIT  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;

    logic [2:0]             state_reg, state_next;
    logic [1:0]             ch_reg, ch_next;
    logic                   upd_reg, upd_next;
    logic                   m_valid_reg, m_valid_next;
    logic [SUM_W-1:0]       sum_b_reg, sum_b_next;
    logic [SUM_W-1:0]       sum_g_reg, sum_g_next;
    logic [SUM_W-1:0]       sum_r_reg, sum_r_next;
    logic [GAIN_W-1:0]      gain_b_reg, gain_b_next;
    logic [GAIN_W-1:0]      gain_g_reg, gain_g_next;
    logic [GAIN_W-1:0]      gain_r_reg, gain_r_next;
    logic [TOT_W-1:0]       total_reg, total_next;
    logic [3*PIX_W-1:0]     hold_pix_reg, hold_pix_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                   m_user_reg, m_user_next;
    logic                   out_free;
    logic [3*PIX_W-1:0]     pix_out;

    function automatic logic [PIX_W-1:0] apply_gain(input logic [PIX_W-1:0] p,
                                                    input logic [GAIN_W-1:0] g);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] scaled;
        prod   = PROD_W'(p) * PROD_W'(g) + ROUND_HALF;
        scaled = prod >> GAIN_FRAC_BITS;
        apply_gain = (scaled > PROD_W'(PIX_MAX)) ? PIX_MAX : scaled[PIX_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                 input logic [PIX_W-1:0] v);
        logic [SUMX_W-1:0] s;
        s = {1'b0, acc} + SUMX_W'(v);
        sat_add = s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign q_pop         = (state_reg == ST_RUN) && q_valid && out_free;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign div_total     = total_reg;
    assign pix_out       = {apply_gain(q_item.red, gain_r_reg),
                            apply_gain(q_item.green, gain_g_reg),
                            apply_gain(q_item.blue, gain_b_reg)};

    always_comb begin
        case (ch_reg)
            CH_BLUE:  div_chan = sum_b_reg;
            CH_GREEN: div_chan = sum_g_reg;
            default:  div_chan = sum_r_reg;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        ch_next       = ch_reg;
        upd_next      = upd_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        sum_b_next    = sum_b_reg;
        sum_g_next    = sum_g_reg;
        sum_r_next    = sum_r_reg;
        gain_b_next   = gain_b_reg;
        gain_g_next   = gain_g_reg;
        gain_r_next   = gain_r_reg;
        total_next    = total_reg;
        hold_pix_next = hold_pix_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        div_start     = 1'b0;
        unique case (state_reg)
            ST_RUN: begin
                if (q_pop) begin
                    if (q_item.near_gray) begin
                        sum_b_next = sat_add(sum_b_reg, q_item.blue);
                        sum_g_next = sat_add(sum_g_reg, q_item.green);
                        sum_r_next = sat_add(sum_r_reg, q_item.red);
                    end
                    if (q_item.last) begin
                        hold_pix_next = pix_out;
                        state_next    = ST_TOTAL;
                    end else begin
                        m_valid_next = 1'b1;
                        m_data_next  = {gain_r_reg, gain_g_reg, gain_b_reg, pix_out};
                        m_user_next  = 1'b0;
                    end
                end
            end
            ST_TOTAL: begin
                total_next = TOT_W'(sum_b_reg) + TOT_W'(sum_g_reg) + TOT_W'(sum_r_reg);
                ch_next    = CH_BLUE;
                state_next = ST_START;
            end
            ST_START: begin
                if (total_reg == '0) begin
                    upd_next   = 1'b0;
                    state_next = ST_EMIT;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (div_stat.done) begin
                    case (ch_reg)
                        CH_BLUE:  gain_b_next = div_quot;
                        CH_GREEN: gain_g_next = div_quot;
                        default:  gain_r_next = div_quot;
                    endcase
                    if (ch_reg == CH_RED) begin
                        upd_next   = 1'b1;
                        state_next = ST_EMIT;
                    end else begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = ST_START;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {gain_r_reg, gain_g_reg, gain_b_reg, hold_pix_reg};
                    m_user_next  = upd_reg;
                    sum_b_next   = '0;
                    sum_g_next   = '0;
                    sum_r_next   = '0;
                    state_next   = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            ch_reg      <= CH_BLUE;
            upd_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            sum_b_reg   <= '0;
            sum_g_reg   <= '0;
            sum_r_reg   <= '0;
            gain_b_reg  <= UNITY_GAIN;
            gain_g_reg  <= UNITY_GAIN;
            gain_r_reg  <= UNITY_GAIN;
        end else begin
            state_reg   <= state_next;
            ch_reg      <= ch_next;
            upd_reg     <= upd_next;
            m_valid_reg <= m_valid_next;
            sum_b_reg   <= sum_b_next;
            sum_g_reg   <= sum_g_next;
            sum_r_reg   <= sum_r_next;
            gain_b_reg  <= gain_b_next;
            gain_g_reg  <= gain_g_next;
            gain_r_reg  <= gain_r_next;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg    <= total_next;
        hold_pix_reg <= hold_pix_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/gray_world_white_balance_core.sv
// An ordinary pixel reaches m_axis through the queue and then the output register.
// Throughput: one pixel per cycle while no frame end is in work and m_axis_tready holds no output.
// Frame end: the last pixel's result waits for the gain update, which runs the gains in turn,
//   per gain: start, setup, range check, 16 quotient steps, done.
// Reset (aresetn, synchronous, active low): sums clear, gains go to unity, chroma
//   window returns to [110, 145], queue and output register empty.
`default_nettype none

`include "gray_world_white_balance_core_macros.svh"

module gray_world_white_balance_core
    import gwwb_pkg::*;
#(
    parameter int PIXEL_COUNT_BITS = 22,
    parameter int GAIN_FRAC_BITS   = 12
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Configuration writes: index 0 chroma_high, index 1 chroma_low.
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data,
    // Pixel input.
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata, low to high: pix_blue, pix_green, pix_red, chroma_a, chroma_b
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tlast: frame_last
    input  wire logic                   s_axis_tlast,
    // Balanced pixel output.
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata, low to high: out_blue, out_green, out_red, gain_blue, gain_green, gain_red
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: gains_updated
    output logic                        m_axis_tuser
);

    gwwb_item_t                    push_item;
    gwwb_item_t                    q_head;
    logic                          q_push;
    logic                          q_pop;
    logic                          q_full;
    logic                          q_valid;
    logic                          div_start;
    logic [PIXEL_COUNT_BITS+9:0]   div_total;
    logic [PIXEL_COUNT_BITS+7:0]   div_chan;
    gwwb_div_stat_t                div_stat;
    logic [GAIN_W-1:0]             div_quot;

    // Front: hold the chroma window, classify each pixel and push it.
    gwwb_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (push_item)
    );

    // Queue: decouple input acceptance from the frame-end stall of the back.
    gwwb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    // Back: apply held gains, accumulate gray sums, sequence the gain update.
    gwwb_back #(
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS),
        .GAIN_FRAC_BITS   (GAIN_FRAC_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_item        (q_head),
        .q_pop         (q_pop),
        .div_start     (div_start),
        .div_total     (div_total),
        .div_chan      (div_chan),
        .div_stat      (div_stat),
        .div_quot      (div_quot),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Divider: one channel gain per run, shared by all three channels.
    gwwb_div #(
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS),
        .GAIN_FRAC_BITS   (GAIN_FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .total   (div_total),
        .chan    (div_chan),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    // Never launch a division while the previous one is still running.
    `GWWB_ASSERT_IMP(a_div_start_idle, aclk, aresetn, div_start, !div_stat.busy)
    // Hold the queue while a division result comes back.
    `GWWB_ASSERT_IMP(a_no_pop_on_done, aclk, aresetn, div_stat.done, !q_pop)
    // After a frame's last pixel leaves the queue, stall the queue for the gain update.
    `GWWB_ASSERT_NXT(a_stall_after_last, aclk, aresetn, q_pop && q_head.last, !q_pop)

endmodule

`default_nettype wire
